// ----- hdl/ansi_color_span_parser_top_defines.svh -----
// ----------------------------------------------------------------------------
// ANSI color span parser assertion macros
// Shared concurrent assertion forms for the span parser.
// ----------------------------------------------------------------------------
`ifndef ANSI_COLOR_SPAN_PARSER_TOP_DEFINES_SVH
`define ANSI_COLOR_SPAN_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ASCP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ascp_pkg.sv -----
// ----------------------------------------------------------------------------
// ascp_pkg
// Types and constants for the ANSI SGR color span parser.
// ----------------------------------------------------------------------------
package ascp_pkg;

   // Parse modes
   localparam logic [2:0] MODE_TEXT   = 3'd0;
   localparam logic [2:0] MODE_ESC    = 3'd1;
   localparam logic [2:0] MODE_EXPECT = 3'd2;
   localparam logic [2:0] MODE_NUMBER = 3'd3;
   localparam logic [2:0] MODE_ERROR  = 3'd4;

   // Result kinds
   localparam logic [1:0] KIND_SPAN  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Characters
   localparam logic [7:0] CHAR_ESC   = 8'h1B;
   localparam logic [7:0] CHAR_LBRK  = 8'h5B;
   localparam logic [7:0] CHAR_M     = 8'h6D;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // SGR codes
   localparam int SGR_RESET   = 0;
   localparam int SGR_EXT_FG  = 38;
   localparam int SGR_RGB     = 2;
   localparam int SGR_DEFAULT = 39;
   localparam int SGR_FG_LO   = 30;
   localparam int SGR_FG_HI   = 37;

   localparam int           MAX_PARAMS = 5;
   localparam int           PIDX_BITS  = 3;
   localparam logic [7:0]   COMP_FULL  = 8'hFF;

   // One input beat
   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } ascp_item_type;

   // One result beat, with a flag telling whether it is produced
   typedef struct packed {
      logic        emit;
      logic [1:0]  result_kind;
      logic [15:0] span_start;
      logic [15:0] span_length;
      logic        color_set;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        end_of_results;
   } ascp_result_type;

   // Parser status seen by the top level
   typedef struct packed {
      logic [2:0] mode;
      logic       at_start;
   } ascp_status_type;

endpackage

// ----- hdl/ascp_if.sv -----
// ----------------------------------------------------------------------------
// ascp_req_if / ascp_rsp_if
// Valid/ready channels for input bytes and parser results.
// ----------------------------------------------------------------------------
interface ascp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface ascp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [15:0] span_start;
   logic [15:0] span_length;
   logic        color_set;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic        end_of_results;

   modport source (output valid, output result_kind, output span_start,
                   output span_length, output color_set, output red,
                   output green, output blue, output end_of_results,
                   input ready);
   modport sink   (input valid, input result_kind, input span_start,
                   input span_length, input color_set, input red,
                   input green, input blue, input end_of_results,
                   output ready);
endinterface

// ----- hdl/ascp_in_stage.sv -----
// ----------------------------------------------------------------------------
// ascp_in_stage
// Input register: holds one byte beat until the parser consumes it.
// ----------------------------------------------------------------------------
module ascp_in_stage
   import ascp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ascp_req_if.sink      req_port,
   input  logic          advance,
   output logic          item_valid,
   output ascp_item_type item
);

   logic          valid_ff, valid_in;
   ascp_item_type item_ff, item_in;
   logic          take;

   // Take a new beat when empty or when the held beat moves on this cycle
   assign req_port.ready = !valid_ff || advance;
   assign take           = req_port.valid && req_port.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in           = 1'b1;
         item_in.text_byte  = req_port.text_byte;
         item_in.final_byte = req_port.final_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- hdl/ascp_parse.sv -----
// ----------------------------------------------------------------------------
// ascp_parse
// Parser state and one-step next-state / result logic per byte.
// ----------------------------------------------------------------------------
module ascp_parse
   import ascp_pkg::*;
#(
   parameter int POSITION_BITS = 16,
   parameter int PARAM_BITS    = 16
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  ascp_item_type   item,
   output ascp_result_type result,
   output ascp_status_type status
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [PARAM_BITS-1:0]    PAR_MAX = '1;

   // State registers
   logic [2:0]               mode_ff, mode_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [POSITION_BITS-1:0] span_begin_ff, span_begin_in;
   logic                     seen_ff, seen_in;
   logic                     color_valid_ff, color_valid_in;
   logic [7:0]               red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [PIDX_BITS-1:0]     count_ff, count_in;
   logic [PARAM_BITS-1:0]    params_ff [MAX_PARAMS];
   logic [PARAM_BITS-1:0]    param_wdata;
   logic [PIDX_BITS-1:0]     param_widx;
   logic                     param_we;

   // Datapath helpers
   logic [7:0]               b;
   logic                     fin, is_digit;
   logic [3:0]               digit;
   logic [PIDX_BITS-1:0]     last_idx;
   logic [PARAM_BITS-1:0]    last_val;
   logic [PARAM_BITS+3:0]    mac;
   logic [PARAM_BITS-1:0]    mac_sat;
   logic [PARAM_BITS-1:0]    code;
   logic [2:0]               prim;
   logic [POSITION_BITS-1:0] pos_m1;
   logic [POSITION_BITS:0]   pos_p1, end_len;
   logic [POSITION_BITS:0]   begin_wide;
   logic                     end_span;

   assign b        = item.text_byte;
   assign fin      = item.final_byte;
   assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign digit    = b[3:0];

   // Decimal accumulate on the last parameter, saturating
   assign last_idx = count_ff - PIDX_BITS'(1);
   assign last_val = params_ff[last_idx];
   assign mac      = {1'b0, last_val, 3'b000} + {3'b000, last_val, 1'b0}
                     + (PARAM_BITS+4)'(digit);
   assign mac_sat  = (mac[PARAM_BITS+3:PARAM_BITS] != 4'd0) ? PAR_MAX
                                                             : mac[PARAM_BITS-1:0];

   assign code = params_ff[0];
   assign prim = 3'(code - PARAM_BITS'(SGR_FG_LO));

   assign pos_m1 = position_ff - POSITION_BITS'(1);
   assign pos_p1 = {1'b0, position_ff} + (POSITION_BITS+1)'(1);

   // Next state and result
   always_comb begin
      mode_in        = mode_ff;
      position_in    = position_ff;
      span_begin_in  = span_begin_ff;
      seen_in        = seen_ff;
      color_valid_in = color_valid_ff;
      red_in         = red_ff;
      green_in       = green_ff;
      blue_in        = blue_ff;
      count_in       = count_ff;
      param_we       = 1'b0;
      param_widx     = count_ff;
      param_wdata    = PARAM_BITS'(digit);
      result         = '0;
      end_len        = '0;
      end_span       = 1'b0;
      begin_wide     = {1'b0, span_begin_ff};

      case (mode_ff)
         MODE_TEXT: begin
            if (b == CHAR_ESC) mode_in = MODE_ESC;
         end
         MODE_ESC: begin
            if (b == CHAR_LBRK) begin
               if (fin) begin
                  mode_in = MODE_ERROR;
               end else begin
                  // close text before the sequence
                  if ((position_ff != '0) && (pos_m1 > span_begin_ff)) begin
                     result.emit        = 1'b1;
                     result.result_kind = KIND_SPAN;
                     result.span_start  = 16'(span_begin_ff);
                     result.span_length = 16'(pos_m1 - span_begin_ff);
                     result.color_set   = color_valid_ff;
                     result.red         = red_ff;
                     result.green       = green_ff;
                     result.blue        = blue_ff;
                  end
                  mode_in  = MODE_EXPECT;
                  seen_in  = 1'b1;
                  count_in = '0;
               end
            end else if (b != CHAR_ESC) begin
               mode_in = MODE_TEXT;
            end
         end
         MODE_EXPECT, MODE_NUMBER: begin
            if (is_digit) begin
               if (mode_ff == MODE_EXPECT) begin
                  if (count_ff < PIDX_BITS'(MAX_PARAMS)) param_we = 1'b1;
                  if (count_ff <= PIDX_BITS'(MAX_PARAMS))
                     count_in = count_ff + PIDX_BITS'(1);
               end else if ((count_ff != '0) && (count_ff <= PIDX_BITS'(MAX_PARAMS))) begin
                  param_we    = 1'b1;
                  param_widx  = last_idx;
                  param_wdata = mac_sat;
               end
               mode_in = MODE_NUMBER;
            end else if (b == CHAR_SEMI) begin
               mode_in = (mode_ff == MODE_NUMBER) ? MODE_EXPECT : MODE_ERROR;
            end else if (b == CHAR_M) begin
               // apply the SGR sequence
               if ((count_ff == PIDX_BITS'(MAX_PARAMS))
                   && (params_ff[0] == PARAM_BITS'(SGR_EXT_FG))
                   && (params_ff[1] == PARAM_BITS'(SGR_RGB))) begin
                  color_valid_in = 1'b1;
                  red_in         = params_ff[2][7:0];
                  green_in       = params_ff[3][7:0];
                  blue_in        = params_ff[4][7:0];
               end else if (count_ff != '0) begin
                  if ((code == PARAM_BITS'(SGR_RESET)) || (code == PARAM_BITS'(SGR_DEFAULT))) begin
                     color_valid_in = 1'b0;
                     red_in         = '0;
                     green_in       = '0;
                     blue_in        = '0;
                  end else if ((code >= PARAM_BITS'(SGR_FG_LO))
                               && (code <= PARAM_BITS'(SGR_FG_HI))) begin
                     color_valid_in = 1'b1;
                     red_in         = prim[0] ? COMP_FULL : 8'd0;
                     green_in       = prim[1] ? COMP_FULL : 8'd0;
                     blue_in        = prim[2] ? COMP_FULL : 8'd0;
                  end
               end
               mode_in       = MODE_TEXT;
               span_begin_in = pos_p1[POSITION_BITS-1:0];
               // full-width start, so a sequence closing on the last offset leaves no span
               begin_wide    = pos_p1;
            end else begin
               mode_in = MODE_ERROR;
            end
         end
         default: begin
            mode_in = MODE_ERROR;
         end
      endcase

      if (fin) begin
         // final byte: one result, then back to the reset state
         result.emit           = 1'b1;
         result.end_of_results = 1'b1;
         if ((mode_in == MODE_TEXT) || (mode_in == MODE_ESC)) begin
            end_span = seen_in && (pos_p1 > begin_wide);
            end_len  = pos_p1 - begin_wide;
            if (end_span) begin
               result.result_kind = KIND_SPAN;
               result.span_start  = 16'(span_begin_in);
               result.span_length = 16'(end_len);
               result.color_set   = color_valid_in;
               result.red         = red_in;
               result.green       = green_in;
               result.blue        = blue_in;
            end else begin
               result.result_kind = KIND_END;
            end
         end else begin
            result.result_kind = KIND_ERROR;
         end
         mode_in        = MODE_TEXT;
         position_in    = '0;
         span_begin_in  = '0;
         seen_in        = 1'b0;
         color_valid_in = 1'b0;
         red_in         = '0;
         green_in       = '0;
         blue_in        = '0;
         count_in       = '0;
      end else if (position_ff == POS_MAX) begin
         mode_in = MODE_ERROR;
      end else begin
         position_in = pos_p1[POSITION_BITS-1:0];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_TEXT;
         position_ff    <= '0;
         span_begin_ff  <= '0;
         seen_ff        <= 1'b0;
         color_valid_ff <= 1'b0;
         red_ff         <= '0;
         green_ff       <= '0;
         blue_ff        <= '0;
         count_ff       <= '0;
      end else if (step) begin
         mode_ff        <= mode_in;
         position_ff    <= position_in;
         span_begin_ff  <= span_begin_in;
         seen_ff        <= seen_in;
         color_valid_ff <= color_valid_in;
         red_ff         <= red_in;
         green_ff       <= green_in;
         blue_ff        <= blue_in;
         count_ff       <= count_in;
      end
   end

   // Parameter store, written only when a digit lands
   always_ff @(posedge clock) begin
      if (step && param_we) begin
         params_ff[param_widx] <= param_wdata;
      end
   end

   assign status.mode     = mode_ff;
   assign status.at_start = (mode_ff == MODE_TEXT) && (position_ff == '0) && !seen_ff;

endmodule

// ----- hdl/ascp_out_stage.sv -----
// ----------------------------------------------------------------------------
// ascp_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module ascp_out_stage
   import ascp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  ascp_result_type result,
   output logic            out_free,
   ascp_rsp_if.source      rsp_port
);

   logic            valid_ff, valid_in;
   ascp_result_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_port.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_port.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_port.valid          = valid_ff;
   assign rsp_port.result_kind    = data_ff.result_kind;
   assign rsp_port.span_start     = data_ff.span_start;
   assign rsp_port.span_length    = data_ff.span_length;
   assign rsp_port.color_set      = data_ff.color_set;
   assign rsp_port.red            = data_ff.red;
   assign rsp_port.green          = data_ff.green;
   assign rsp_port.blue           = data_ff.blue;
   assign rsp_port.end_of_results = data_ff.end_of_results;

endmodule

// ----- hdl/ansi_color_span_parser_top.sv -----
// ----------------------------------------------------------------------------
// ansi_color_span_parser_top
// Path: a byte beat taken on req waits in the input register; the parse step
// sits between it and the result register, the only point of backpressure.
// Throughput: one byte per cycle while the result register is not stalled.
// Reset: synchronous, active high; returns the parser to text mode at offset 0.
// ----------------------------------------------------------------------------
`include "ansi_color_span_parser_top_defines.svh"

module ansi_color_span_parser_top
   import ascp_pkg::*;
#(
   parameter int POSITION_BITS = 16,
   parameter int PARAM_BITS    = 16
)(
   input  logic       clock,
   input  logic       reset,
   ascp_req_if.sink   req_port,
   ascp_rsp_if.source rsp_port
);

   logic            item_valid;
   ascp_item_type   item;
   logic            out_free;
   logic            advance;
   ascp_result_type result;
   ascp_status_type status;

   // Parse step fires when a byte is held and the result slot can take it
   assign advance = item_valid && out_free;

   ascp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ascp_parse #(
      .POSITION_BITS (POSITION_BITS),
      .PARAM_BITS    (PARAM_BITS)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .result (result),
      .status (status)
   );

   ascp_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && result.emit),
      .result   (result),
      .out_free (out_free),
      .rsp_port (rsp_port)
   );

   // Checks
   `ASCP_ASSERT_NEXT(a_final_clears, clock, reset, advance && item.final_byte, status.at_start, "parser not back at start after final byte")
   `ASCP_ASSERT_IMPL(a_mid_is_span, clock, reset, rsp_port.valid && !rsp_port.end_of_results, rsp_port.result_kind == KIND_SPAN, "non-final result is not a span")
   `ASCP_ASSERT_IMPL(a_nonspan_zero, clock, reset, rsp_port.valid && (rsp_port.result_kind != KIND_SPAN), (rsp_port.span_length == 16'd0) && !rsp_port.color_set && (rsp_port.red == 8'd0), "end or error beat carries span data")
   `ASCP_ASSERT_IMPL(a_plain_color, clock, reset, rsp_port.valid && !rsp_port.color_set, (rsp_port.red == 8'd0) && (rsp_port.green == 8'd0) && (rsp_port.blue == 8'd0), "uncolored beat carries a color")

endmodule

// ----- tb/ascp_span_checker.sv -----
// ----------------------------------------------------------------------------
// ascp_span_checker
// Watches the byte and result channels of the ANSI color span parser. Every
// accepted byte beat goes through a local model of the SGR parser; any result
// it gives is queued and compared field by field, in order, with result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ascp_span_checker
   import ascp_pkg::*;
#(
   parameter int POSITION_BITS = 16,
   parameter int PARAM_BITS    = 16
)(
   input  logic  clock,
   input  logic  reset,
   ascp_req_if   req_mon,
   ascp_rsp_if   rsp_mon,
   output int    error_count,
   output int    pending_count
);

   localparam longint POS_LIMIT   = (longint'(1) << POSITION_BITS) - 1;
   localparam longint PARAM_LIMIT = (longint'(1) << PARAM_BITS) - 1;

   // Model state
   logic [2:0] mode;
   longint     pos_now;
   longint     span_from;
   logic       seen;
   logic       hue_on;
   logic [7:0] hue_r;
   logic [7:0] hue_g;
   logic [7:0] hue_b;
   longint     params [MAX_PARAMS];
   int         nparams;

   ascp_result_type expected_results[$];
   int              errors  = 0;
   int              pending = 0;

   assign error_count   = errors;
   assign pending_count = pending;

   function automatic void clear_parse_state();
      mode      = MODE_TEXT;
      pos_now   = 0;
      span_from = 0;
      seen      = 1'b0;
      hue_on    = 1'b0;
      hue_r     = '0;
      hue_g     = '0;
      hue_b     = '0;
      nparams   = 0;
      for (int i = 0; i < MAX_PARAMS; i++) params[i] = 0;
   endfunction

   // Color change at the closing 'm' of a sequence
   function automatic void apply_sgr();
      int bits;
      if (nparams == MAX_PARAMS && params[0] == SGR_EXT_FG && params[1] == SGR_RGB) begin
         hue_on = 1'b1;
         hue_r  = 8'(params[2]);
         hue_g  = 8'(params[3]);
         hue_b  = 8'(params[4]);
      end else if (nparams > 0) begin
         if (params[0] == SGR_RESET || params[0] == SGR_DEFAULT) begin
            hue_on = 1'b0;
            hue_r  = '0;
            hue_g  = '0;
            hue_b  = '0;
         end else if (params[0] >= SGR_FG_LO && params[0] <= SGR_FG_HI) begin
            bits   = int'(params[0]) - SGR_FG_LO;
            hue_on = 1'b1;
            hue_r  = bits[0] ? COMP_FULL : 8'h00;
            hue_g  = bits[1] ? COMP_FULL : 8'h00;
            hue_b  = bits[2] ? COMP_FULL : 8'h00;
         end
      end
   endfunction

   function automatic ascp_result_type span_result(longint start, longint len, logic last);
      ascp_result_type r;
      r                = '0;
      r.emit           = 1'b1;
      r.result_kind    = KIND_SPAN;
      r.span_start     = 16'(start);
      r.span_length    = 16'(len);
      r.color_set      = hue_on;
      r.red            = hue_on ? hue_r : 8'h00;
      r.green          = hue_on ? hue_g : 8'h00;
      r.blue           = hue_on ? hue_b : 8'h00;
      r.end_of_results = last;
      return r;
   endfunction

   // One byte through the parser; res.emit tells whether a result comes out
   function automatic void parse_byte(input logic [7:0] b, input logic fin,
                                      output ascp_result_type res);
      longint pos;
      longint v;
      int     digit;
      pos = pos_now;
      res = '0;
      case (mode)
         MODE_TEXT: begin
            if (b == CHAR_ESC) mode = MODE_ESC;
         end
         MODE_ESC: begin
            if (b == CHAR_LBRK) begin
               if (fin) begin
                  mode = MODE_ERROR;
               end else begin
                  // text before the sequence closes as a span
                  if (pos >= 1 && pos - 1 > span_from)
                     res = span_result(span_from, pos - 1 - span_from, 1'b0);
                  mode    = MODE_EXPECT;
                  seen    = 1'b1;
                  nparams = 0;
               end
            end else if (b != CHAR_ESC) begin
               mode = MODE_TEXT;
            end
         end
         MODE_EXPECT, MODE_NUMBER: begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               digit = int'(b - CHAR_ZERO);
               if (mode == MODE_EXPECT) begin
                  if (nparams < MAX_PARAMS) params[nparams] = digit;
                  if (nparams <= MAX_PARAMS) nparams++;
               end else if (nparams >= 1 && nparams <= MAX_PARAMS) begin
                  v = params[nparams-1] * 10 + digit;
                  params[nparams-1] = (v > PARAM_LIMIT) ? PARAM_LIMIT : v;
               end
               mode = MODE_NUMBER;
            end else if (b == CHAR_SEMI) begin
               mode = (mode == MODE_NUMBER) ? MODE_EXPECT : MODE_ERROR;
            end else if (b == CHAR_M) begin
               apply_sgr();
               mode      = MODE_TEXT;
               span_from = pos + 1;
            end else begin
               mode = MODE_ERROR;
            end
         end
         default: mode = MODE_ERROR;
      endcase

      if (fin) begin
         if (mode == MODE_TEXT || mode == MODE_ESC) begin
            if (seen && pos + 1 > span_from) begin
               res = span_result(span_from, pos + 1 - span_from, 1'b1);
            end else begin
               res                = '0;
               res.emit           = 1'b1;
               res.result_kind    = KIND_END;
               res.end_of_results = 1'b1;
            end
         end else begin
            res                = '0;
            res.emit           = 1'b1;
            res.result_kind    = KIND_ERROR;
            res.end_of_results = 1'b1;
         end
         clear_parse_state();
      end else if (pos >= POS_LIMIT) begin
         mode = MODE_ERROR;
      end else begin
         pos_now = pos + 1;
      end
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   // Predict on byte beats, compare on result beats
   always @(posedge clock) begin
      ascp_result_type predicted;
      ascp_result_type oldest;
      if (reset) begin
         clear_parse_state();
         expected_results.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            parse_byte(req_mon.text_byte, req_mon.final_byte, predicted);
            if (predicted.emit) expected_results.push_back(predicted);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("result beat with no result expected");
               errors++;
            end else begin
               oldest = expected_results.pop_front();
               check_field("result_kind", 16'(oldest.result_kind), 16'(rsp_mon.result_kind));
               check_field("span_start", oldest.span_start, rsp_mon.span_start);
               check_field("span_length", oldest.span_length, rsp_mon.span_length);
               check_field("color_set", 16'(oldest.color_set), 16'(rsp_mon.color_set));
               check_field("red", 16'(oldest.red), 16'(rsp_mon.red));
               check_field("green", 16'(oldest.green), 16'(rsp_mon.green));
               check_field("blue", 16'(oldest.blue), 16'(rsp_mon.blue));
               check_field("end_of_results", 16'(oldest.end_of_results),
                           16'(rsp_mon.end_of_results));
            end
         end
      end
      pending = expected_results.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the ANSI color span parser: short directed strings, then
// random strings of plain text and well-formed, broken or open SGR sequences
// with random content. Both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import ascp_pkg::*;

   localparam logic [7:0] ESC_MARK     = "^";   // stands for ESC in directed text
   localparam int         RANDOM_ITEMS = 1890;

   logic clock;
   logic reset;
   bit   quiet = 1'b0;
   int   items_sent = 0;
   int   fail_count;
   int   pending;

   logic [7:0] line_buf[$];

   ascp_req_if req_bus();
   ascp_rsp_if rsp_bus();

   ansi_color_span_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   ascp_span_checker u_span_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .error_count   (fail_count),
      .pending_count (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side backpressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever @(negedge clock) rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 26);
   end

   function automatic void push_byte(logic [7:0] b);
      line_buf.push_back(b);
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++)
         line_buf.push_back((s[i] == ESC_MARK) ? CHAR_ESC : s[i]);
   endfunction

   function automatic void push_number(longint v);
      if ($urandom_range(0, 7) == 0) push_byte(CHAR_ZERO);
      push_text($sformatf("%0d", v));
   endfunction

   function automatic longint rand_param();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return $urandom_range(0, 255);
      if (sel < 8) return $urandom_range(0, 999);
      return $urandom_range(60000, 9999999);
   endfunction

   // One byte beat; valid goes low only on idle cycles
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while (!quiet && $urandom_range(0, 99) < 26) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.text_byte  <= b;
      req_bus.final_byte <= fin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Send the buffered string, final mark on its last byte
   task automatic flush_line();
      int n;
      n = line_buf.size();
      for (int i = 0; i < n; i++) send_byte(line_buf[i], i == n - 1);
      line_buf.delete();
   endtask

   task automatic make_random_line();
      int         tokens;
      int         sel;
      int         n;
      bit         open_end;
      logic [7:0] b;
      tokens   = $urandom_range(1, 6);
      open_end = 1'b0;
      for (int t = 0; t < tokens && !open_end; t++) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            // plain text, lone ESC now and then
            n = $urandom_range(0, 8);
            for (int j = 0; j < n; j++)
               push_byte(($urandom_range(0, 7) == 0) ? CHAR_ESC : 8'($urandom_range(0, 255)));
         end else if (sel < 80) begin
            // well-formed sequence
            push_byte(CHAR_ESC);
            if ($urandom_range(0, 9) == 0) push_byte(CHAR_ESC);
            push_byte(CHAR_LBRK);
            case ($urandom_range(0, 5))
               0: ;
               1: push_number($urandom_range(SGR_FG_LO, SGR_FG_HI));
               2: push_number($urandom_range(0, 1) ? SGR_RESET : SGR_DEFAULT);
               3: begin
                  push_number(SGR_EXT_FG);
                  push_byte(CHAR_SEMI);
                  push_number(SGR_RGB);
                  for (int j = 0; j < 3; j++) begin
                     push_byte(CHAR_SEMI);
                     push_number(rand_param());
                  end
               end
               4: begin
                  n = $urandom_range(1, 7);
                  for (int j = 0; j < n; j++) begin
                     if (j > 0) push_byte(CHAR_SEMI);
                     push_number($urandom_range(0, 99));
                  end
               end
               default: push_number(rand_param());
            endcase
            push_byte(CHAR_M);
         end else if (sel < 90) begin
            // broken sequence followed by bytes that get ignored
            push_byte(CHAR_ESC);
            push_byte(CHAR_LBRK);
            case ($urandom_range(0, 2))
               0: push_byte(CHAR_SEMI);
               1: begin
                  push_number($urandom_range(0, 99));
                  push_byte(CHAR_SEMI);
                  push_byte(CHAR_SEMI);
               end
               default: begin
                  if ($urandom_range(0, 1)) push_number($urandom_range(0, 99));
                  b = 8'($urandom_range(0, 255));
                  while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_SEMI || b == CHAR_M)
                     b = 8'($urandom_range(0, 255));
                  push_byte(b);
               end
            endcase
            n = $urandom_range(0, 4);
            for (int j = 0; j < n; j++) push_byte(8'($urandom_range(0, 255)));
         end else begin
            // sequence left open at the end of the string
            push_byte(CHAR_ESC);
            push_byte(CHAR_LBRK);
            n = $urandom_range(0, 2);
            for (int j = 0; j < n; j++) begin
               if (j > 0) push_byte(CHAR_SEMI);
               push_number($urandom_range(0, 99));
            end
            open_end = 1'b1;
         end
      end
      if (line_buf.size() == 0) push_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int start;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.text_byte  = '0;
      req_bus.final_byte = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed strings
      push_byte(8'h00);
      push_byte(8'hFF);
      flush_line();
      push_text("a^^[31mb");
      flush_line();
      push_text("^[38;2;7;0;99999mz^[m");
      flush_line();
      push_text("^[1;2;3;4;5;6mq");
      flush_line();
      push_text("^[1;;mzz");
      flush_line();
      push_text("^[4x");
      flush_line();
      push_text("^[31");
      flush_line();
      push_text("^[");
      flush_line();
      push_text("hi^");
      flush_line();

      // Random strings, with one stretch free of stalls
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         quiet = (items_sent - start > 900) && (items_sent - start < 1250);
         make_random_line();
         flush_line();
      end
      quiet = 1'b0;

      req_bus.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Run limit
   initial begin
      #(64'd40_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ascp_pkg.sv
hdl/ascp_if.sv
hdl/ascp_in_stage.sv
hdl/ascp_parse.sv
hdl/ascp_out_stage.sv
hdl/ansi_color_span_parser_top.sv
tb/ascp_span_checker.sv
tb/tb_top.sv
